// File: src/tlph_pkg.sv
// Shared types, item codes and the byte permutation for the two-lane Pearson hash.
// No dependencies; used by every other file of the block.
package tlph_pkg;

  // Item kinds carried on the input channel
  localparam logic [1:0] KIND_PAIR   = 2'd0;  // byte pair, one byte to each lane
  localparam logic [1:0] KIND_SINGLE = 2'd1;  // trailing byte to lane zero only
  localparam logic [1:0] KIND_NONE   = 2'd2;  // no bytes

  // Shift clamp: larger register values act as this
  localparam int unsigned SHIFT_MAX = 8;

  // One input beat as held in the input stage
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_even;
    logic [7:0] byte_odd;
    logic       start_req;
    logic       last;
  } item_t;

  // Both lane accumulators
  typedef struct packed {
    logic [7:0] lane_one;
    logic [7:0] lane_zero;
  } lanes_t;

  // Fixed 256-entry byte permutation
  localparam logic [7:0] PERM [256] = '{
    8'd39, 8'd159, 8'd180, 8'd252, 8'd71, 8'd6, 8'd13, 8'd164,
    8'd232, 8'd35, 8'd226, 8'd155, 8'd98, 8'd120, 8'd154, 8'd69,
    8'd157, 8'd24, 8'd137, 8'd29, 8'd147, 8'd78, 8'd121, 8'd85,
    8'd112, 8'd8, 8'd248, 8'd130, 8'd55, 8'd117, 8'd190, 8'd160,
    8'd176, 8'd131, 8'd228, 8'd64, 8'd211, 8'd106, 8'd38, 8'd27,
    8'd140, 8'd30, 8'd88, 8'd210, 8'd227, 8'd104, 8'd84, 8'd77,
    8'd75, 8'd107, 8'd169, 8'd138, 8'd195, 8'd184, 8'd70, 8'd90,
    8'd61, 8'd166, 8'd7, 8'd244, 8'd165, 8'd108, 8'd219, 8'd51,
    8'd9, 8'd139, 8'd209, 8'd40, 8'd31, 8'd202, 8'd58, 8'd179,
    8'd116, 8'd33, 8'd207, 8'd146, 8'd76, 8'd60, 8'd242, 8'd124,
    8'd254, 8'd197, 8'd80, 8'd167, 8'd153, 8'd145, 8'd129, 8'd233,
    8'd132, 8'd48, 8'd246, 8'd86, 8'd156, 8'd177, 8'd36, 8'd187,
    8'd45, 8'd1, 8'd96, 8'd18, 8'd19, 8'd62, 8'd185, 8'd234,
    8'd99, 8'd16, 8'd218, 8'd95, 8'd128, 8'd224, 8'd123, 8'd253,
    8'd42, 8'd109, 8'd4, 8'd247, 8'd72, 8'd5, 8'd151, 8'd136,
    8'd0, 8'd152, 8'd148, 8'd127, 8'd204, 8'd133, 8'd17, 8'd14,
    8'd182, 8'd217, 8'd54, 8'd199, 8'd119, 8'd174, 8'd82, 8'd57,
    8'd215, 8'd41, 8'd114, 8'd208, 8'd206, 8'd110, 8'd239, 8'd23,
    8'd189, 8'd15, 8'd3, 8'd22, 8'd188, 8'd79, 8'd113, 8'd172,
    8'd28, 8'd2, 8'd222, 8'd21, 8'd251, 8'd225, 8'd237, 8'd105,
    8'd102, 8'd32, 8'd56, 8'd181, 8'd126, 8'd83, 8'd230, 8'd53,
    8'd158, 8'd52, 8'd59, 8'd213, 8'd118, 8'd100, 8'd67, 8'd142,
    8'd220, 8'd170, 8'd144, 8'd115, 8'd205, 8'd26, 8'd125, 8'd168,
    8'd249, 8'd66, 8'd175, 8'd97, 8'd255, 8'd92, 8'd229, 8'd91,
    8'd214, 8'd236, 8'd178, 8'd243, 8'd46, 8'd44, 8'd201, 8'd250,
    8'd135, 8'd186, 8'd150, 8'd221, 8'd163, 8'd216, 8'd162, 8'd43,
    8'd11, 8'd101, 8'd34, 8'd37, 8'd194, 8'd25, 8'd50, 8'd12,
    8'd87, 8'd198, 8'd173, 8'd240, 8'd193, 8'd171, 8'd143, 8'd231,
    8'd111, 8'd141, 8'd191, 8'd103, 8'd74, 8'd245, 8'd223, 8'd20,
    8'd161, 8'd235, 8'd122, 8'd63, 8'd89, 8'd149, 8'd73, 8'd238,
    8'd134, 8'd68, 8'd93, 8'd183, 8'd241, 8'd81, 8'd196, 8'd49,
    8'd192, 8'd65, 8'd212, 8'd94, 8'd203, 8'd10, 8'd200, 8'd47
  };

endpackage

// File: src/tlph_lane_mix.sv
// Next-state logic of both hash lanes for one input beat.
// Depends on tlph_pkg (item_t, lanes_t, kind codes, PERM).
module tlph_lane_mix (
  input  tlph_pkg::item_t  item_i,
  input  tlph_pkg::lanes_t lanes_i,
  output tlph_pkg::lanes_t lanes_o
);

  tlph_pkg::lanes_t base;
  logic [7:0]       mix_zero;
  logic [7:0]       mix_one;

  // Start of a new string clears both lanes first
  always_comb begin
    if (item_i.start_req) begin
      base = '0;
    end else begin
      base = lanes_i;
    end
  end

  // One permutation lookup per lane
  assign mix_zero = tlph_pkg::PERM[base.lane_zero ^ item_i.byte_even];
  assign mix_one  = tlph_pkg::PERM[base.lane_one ^ item_i.byte_odd];

  // Apply by kind; unused codes leave the lanes alone
  always_comb begin
    lanes_o = base;
    unique case (item_i.kind)
      tlph_pkg::KIND_PAIR: begin
        lanes_o.lane_zero = mix_zero;
        lanes_o.lane_one  = mix_one;
      end
      tlph_pkg::KIND_SINGLE: begin
        lanes_o.lane_zero = mix_zero;
      end
      default: begin
        lanes_o = base;
      end
    endcase
  end

endmodule

// File: src/two_lane_pearson_string_hash.sv
// Top level of the two-lane Pearson string hash: input stage, lane registers,
// result register and configuration register. Depends on tlph_pkg, tlph_lane_mix.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per byte pair,
//   trailing single byte or empty item. start_req_i clears both lanes before
//   the beat is applied; last_i makes the block emit one hash after it.
//   Output channel (out_valid_o / out_ready_i) carries hash_value_o, which is
//   (lane_one << table_shift) xor lane_zero, with table_shift clamped to 8.
//   Config channel (cfg_valid_i / cfg_ready_o) writes table_shift; it is
//   always ready and should only be written while the block is idle.
// Path: an accepted last beat is registered in the input stage, and its hash
//   then in the result register, which drives hash_value_o.
// Throughput: one beat per cycle while no last beat waits on a full result slot;
//   set by the lane feedback through one permutation lookup per lane.
// Stall: a waiting result stays in the output register; non-last beats keep
//   flowing, and a last beat waits in the input stage, which then holds off
//   further input until the result is taken.
// Reset: both lanes clear to zero, table_shift returns to 1, no beat pending.
module two_lane_pearson_string_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  byte_even_i,
  input  logic [7:0]  byte_odd_i,
  input  logic        start_req_i,
  input  logic        last_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] hash_value_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  tlph_pkg::item_t  item_q;
  logic             item_valid_q;
  logic             item_fire;
  tlph_pkg::lanes_t lanes_q, lanes_d;
  logic [3:0]       shift_q;
  logic [3:0]       shift_eff;
  logic [15:0]      hash_d;
  logic [15:0]      hash_q;
  logic             out_valid_q;

  // Input stage moves on unless it holds a last beat and the result slot is full and not being taken
  assign item_fire  = item_valid_q &&
                      (!item_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || item_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  // Payload register for the input stage
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind      <= kind_i;
      item_q.byte_even <= byte_even_i;
      item_q.byte_odd  <= byte_odd_i;
      item_q.start_req <= start_req_i;
      item_q.last      <= last_i;
    end
  end

  // Lane update
  tlph_lane_mix u_lane_mix (
    .item_i  (item_q),
    .lanes_i (lanes_q),
    .lanes_o (lanes_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
    end else if (item_fire) begin
      lanes_q <= lanes_d;
    end
  end

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      shift_q <= cfg_data_i;
    end
  end

  // Result: clamp the shift, then fold lane one over lane zero
  assign shift_eff = (shift_q > 4'(tlph_pkg::SHIFT_MAX)) ?
                     4'(tlph_pkg::SHIFT_MAX) : shift_q;
  assign hash_d    = ({8'd0, lanes_d.lane_one} << shift_eff) ^
                     {8'd0, lanes_d.lane_zero};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_fire && item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_fire && item_q.last) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// File: src/tlph_checker.sv
// Port-level checks for two_lane_pearson_string_hash, attached by bind.
// Depends on tlph_pkg (kind codes) and the top level's port list.
module tlph_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        start_req_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] hash_value_o
);

  // A stalled result beat holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_value_o))
    else $error("stalled result beat changed or dropped");

  // Input only backs up behind a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with the result slot empty");

  // A fresh result must follow an accepted last input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_i, 2))
    else $error("result beat without a matching last input beat");

  // An empty name hashes to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) &&
    $past(in_valid_i && in_ready_o && start_req_i &&
          (kind_i == tlph_pkg::KIND_NONE), 2)
    |-> hash_value_o == 16'd0)
    else $error("empty name did not hash to zero");

endmodule

bind two_lane_pearson_string_hash tlph_checker u_tlph_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .kind_i       (kind_i),
  .start_req_i  (start_req_i),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hash_value_o (hash_value_o)
);
